// ===== design/plsum_pkg.sv =====
// ----------------------------------------------------------------------------
// plsum_pkg: shared types and helpers for the multi-lane prefix sum
// Holds the lane split, the scan tree size, the request/result structs and
// the conversions between 32-bit words and the internal element width.
// ----------------------------------------------------------------------------
package plsum_pkg;

  localparam int unsigned LANES         = 8;
  localparam int unsigned ELEMENT_WIDTH = 32;
  localparam int unsigned NUM_ELEMS     = 8;
  localparam int unsigned WORD_WIDTH    = 32;

  // Contiguous chunk split: the first REM lanes take one extra element.
  localparam int unsigned GROUP     = NUM_ELEMS / LANES;
  localparam int unsigned REM       = NUM_ELEMS % LANES;
  localparam int unsigned MAX_CHUNK = GROUP + ((REM != 0) ? 1 : 0);

  // Scan tree is padded with zero totals up to the next power of two.
  function automatic int unsigned tree_size_f();
    int unsigned p;
    p = 1;
    for (int i = 0; i < 8; i++) begin
      if (p < LANES) begin
        p = p * 2;
      end
    end
    return p;
  endfunction

  localparam int unsigned TREE_SIZE   = tree_size_f();
  localparam int unsigned TREE_LEVELS = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [WORD_WIDTH-1:0]    word_t;

  typedef struct packed {
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic signed [31:0] elem_4;
    logic signed [31:0] elem_5;
    logic signed [31:0] elem_6;
    logic signed [31:0] elem_7;
    logic               last;
  } plsum_in_t;

  typedef struct packed {
    logic signed [31:0] sum_0;
    logic signed [31:0] sum_1;
    logic signed [31:0] sum_2;
    logic signed [31:0] sum_3;
    logic signed [31:0] sum_4;
    logic signed [31:0] sum_5;
    logic signed [31:0] sum_6;
    logic signed [31:0] sum_7;
    logic               end_of_array;
  } plsum_out_t;

  // Lane results going into the scan tree.
  typedef struct packed {
    elem_t [LANES-1:0]     tot;
    elem_t [NUM_ELEMS-1:0] part;
    logic                  last;
  } tree_in_t;

  // Exclusive lane offsets coming out of the scan tree.
  typedef struct packed {
    elem_t [LANES-1:0]     off;
    elem_t [NUM_ELEMS-1:0] part;
    logic                  last;
  } tree_out_t;

  function automatic int unsigned chunk_cnt(input int unsigned l);
    return GROUP + ((l < REM) ? 1 : 0);
  endfunction

  function automatic int unsigned chunk_start(input int unsigned l);
    return l * GROUP + ((l < REM) ? l : REM);
  endfunction

  function automatic int unsigned lane_of(input int unsigned k);
    int unsigned r;
    r = 0;
    for (int unsigned l = 0; l < LANES; l++) begin
      if (k >= chunk_start(l)) begin
        r = l;
      end
    end
    return r;
  endfunction

  // Sign-extend or truncate a 32-bit word to the element width.
  function automatic elem_t to_elem(input word_t v);
    elem_t r;
    for (int i = 0; i < ELEMENT_WIDTH; i++) begin
      r[i] = (i < WORD_WIDTH) ? v[i] : v[WORD_WIDTH-1];
    end
    return r;
  endfunction

  // Keep the low 32 bits of an element, zero above a narrow element.
  function automatic word_t to_word(input elem_t v);
    word_t r;
    for (int i = 0; i < WORD_WIDTH; i++) begin
      r[i] = (i < ELEMENT_WIDTH) ? v[i] : 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== design/plsum_lane.sv =====
// ----------------------------------------------------------------------------
// plsum_lane: serial scan of one lane's chunk
// Produces the running sums inside the chunk and the chunk total.
// ----------------------------------------------------------------------------
module plsum_lane (
  input  plsum_pkg::elem_t chunk_i [plsum_pkg::MAX_CHUNK],
  output plsum_pkg::elem_t pfx_o   [plsum_pkg::MAX_CHUNK],
  output plsum_pkg::elem_t total_o
);
  import plsum_pkg::*;

  // Unused chunk slots are tied to zero, so the last sum is the total.
  always_comb begin
    pfx_o[0] = chunk_i[0];
    for (int j = 1; j < MAX_CHUNK; j++) begin
      pfx_o[j] = pfx_o[j-1] + chunk_i[j];
    end
  end

  assign total_o = pfx_o[MAX_CHUNK-1];

endmodule

// ===== design/plsum_tree.sv =====
// ----------------------------------------------------------------------------
// plsum_tree: pipelined up-sweep / down-sweep exclusive scan of lane totals
// One tree level per stage; lane partial sums ride along with the request.
// ----------------------------------------------------------------------------
module plsum_tree (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  plsum_pkg::tree_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plsum_pkg::tree_out_t  out_data_o
);
  import plsum_pkg::*;

  localparam int unsigned NSTG = 2 * TREE_LEVELS;

  elem_t                 tsrc  [NSTG][TREE_SIZE];
  elem_t                 tot_d [NSTG][TREE_SIZE];
  elem_t                 tot_q [NSTG][TREE_SIZE];
  elem_t [NUM_ELEMS-1:0] part_q [NSTG];
  logic  [NSTG-1:0]      last_q;
  logic  [NSTG-1:0]      vld_q;
  logic  [NSTG:0]        rdy;

  assign rdy[NSTG] = out_ready_i;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    assign rdy[s] = !vld_q[s] || rdy[s+1];

    for (genvar i = 0; i < TREE_SIZE; i++) begin : g_src
      if (s == 0) begin : g_first
        if (i < LANES) begin : g_lane
          assign tsrc[s][i] = in_data_i.tot[i];
        end else begin : g_pad
          assign tsrc[s][i] = '0;
        end
      end else if ((s == TREE_LEVELS) && (i == TREE_SIZE - 1)) begin : g_root
        // Clear the root before the down-sweep.
        assign tsrc[s][i] = '0;
      end else begin : g_prev
        assign tsrc[s][i] = tot_q[s-1][i];
      end
    end

    if (s < TREE_LEVELS) begin : g_up
      localparam int unsigned D = 1 << s;
      for (genvar i = 0; i < TREE_SIZE; i++) begin : g_node
        if (((i + 1) % (2 * D)) == 0) begin : g_add
          assign tot_d[s][i] = tsrc[s][i-D] + tsrc[s][i];
        end else begin : g_keep
          assign tot_d[s][i] = tsrc[s][i];
        end
      end
    end else begin : g_down
      localparam int unsigned D = TREE_SIZE >> (s - TREE_LEVELS + 1);
      for (genvar i = 0; i < TREE_SIZE; i++) begin : g_node
        if (((i + 1) % (2 * D)) == 0) begin : g_add
          assign tot_d[s][i] = tsrc[s][i] + tsrc[s][i-D];
        end else if (((i + 1 + D) % (2 * D)) == 0) begin : g_swap
          assign tot_d[s][i] = tsrc[s][i+D];
        end else begin : g_keep
          assign tot_d[s][i] = tsrc[s][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= (s == 0) ? in_valid_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        tot_q[s] <= tot_d[s];
        if (s == 0) begin
          part_q[s] <= in_data_i.part;
          last_q[s] <= in_data_i.last;
        end else begin
          part_q[s] <= part_q[(s == 0) ? 0 : s-1];
          last_q[s] <= last_q[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_data_o.off[l] = tot_q[NSTG-1][l];
    end
    out_data_o.part = part_q[NSTG-1];
    out_data_o.last = last_q[NSTG-1];
  end

endmodule

// ===== design/plsum_merge.sv =====
// ----------------------------------------------------------------------------
// plsum_merge: apply lane offsets, then the running carry
// Two registered stages; the second is the output register and owns the carry.
// ----------------------------------------------------------------------------
module plsum_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  plsum_pkg::tree_out_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plsum_pkg::plsum_out_t out_data_o
);
  import plsum_pkg::*;

  elem_t [NUM_ELEMS-1:0] loc_d, loc_q;
  logic                  last_q;
  logic                  a_vld_q, b_vld_q;
  logic                  a_rdy, b_rdy;
  elem_t                 carry_e;
  elem_t [NUM_ELEMS-1:0] sum_e;
  word_t                 carry_d, carry_q;
  plsum_out_t            out_d, out_q;

  assign b_rdy      = !b_vld_q || out_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  // Stage A: add each lane's exclusive offset to its elements.
  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      loc_d[k] = in_data_i.part[k] + in_data_i.off[lane_of(k)];
    end
  end

  // Stage B: add the carry of earlier vectors.
  assign carry_e = to_elem(carry_q);

  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      sum_e[k] = loc_q[k] + carry_e;
    end
    out_d.sum_0        = to_word(sum_e[0]);
    out_d.sum_1        = to_word(sum_e[1]);
    out_d.sum_2        = to_word(sum_e[2]);
    out_d.sum_3        = to_word(sum_e[3]);
    out_d.sum_4        = to_word(sum_e[4]);
    out_d.sum_5        = to_word(sum_e[5]);
    out_d.sum_6        = to_word(sum_e[6]);
    out_d.sum_7        = to_word(sum_e[7]);
    out_d.end_of_array = last_q;
    carry_d            = last_q ? '0 : to_word(sum_e[NUM_ELEMS-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      carry_q <= '0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
        if (a_vld_q) begin
          carry_q <= carry_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      loc_q  <= loc_d;
      last_q <= in_data_i.last;
    end
    if (b_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = b_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/multi_lane_prefix_sum.sv =====
// ----------------------------------------------------------------------------
// multi_lane_prefix_sum: streaming inclusive prefix sum, eight elements a request
// Each input request carries eight signed 32-bit elements and a last flag; each
// result carries their eight running sums over the whole array, wrapped to
// 32 bits, plus a copy of the flag as end_of_array.
//
// Channels: in_valid_i/in_ready_o/in_data_i and out_valid_o/out_ready_i/
// out_data_o, valid/ready, a request moves when valid and ready are both high.
// Throughput: one request per cycle while the output is not stalled. Every
// stage is an adder level of the scan tree or an offset/carry add; only the
// carry add feeds back, and it closes within the output stage.
// Path: an accepted request passes the scan tree stages, one per up-sweep and
// one per down-sweep tree level, then the merge offset and carry stages.
// Stall: a held result keeps its register; upstream stages keep accepting
// until every bubble is filled, then in_ready_o drops.
// Reset: clears all valid bits and the running carry; no clearing pass.
// After a request with last set, the carry returns to zero.
// ----------------------------------------------------------------------------
module multi_lane_prefix_sum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  plsum_pkg::plsum_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output plsum_pkg::plsum_out_t out_data_o
);
  import plsum_pkg::*;

  elem_t     vec      [NUM_ELEMS];
  elem_t     lane_in  [LANES][MAX_CHUNK];
  elem_t     lane_pfx [LANES][MAX_CHUNK];
  elem_t     lane_tot [LANES];
  elem_t     part_w   [NUM_ELEMS];
  tree_in_t  tree_in;
  tree_out_t tree_out;
  logic      tree_vld, tree_rdy;

  // Widen the request elements to the internal element width.
  assign vec[0] = to_elem(in_data_i.elem_0);
  assign vec[1] = to_elem(in_data_i.elem_1);
  assign vec[2] = to_elem(in_data_i.elem_2);
  assign vec[3] = to_elem(in_data_i.elem_3);
  assign vec[4] = to_elem(in_data_i.elem_4);
  assign vec[5] = to_elem(in_data_i.elem_5);
  assign vec[6] = to_elem(in_data_i.elem_6);
  assign vec[7] = to_elem(in_data_i.elem_7);

  // Split the vector into contiguous chunks, one per lane; pad short chunks.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar j = 0; j < MAX_CHUNK; j++) begin : g_slot
      if (j < chunk_cnt(l)) begin : g_used
        assign lane_in[l][j] = vec[chunk_start(l) + j];
      end else begin : g_pad
        assign lane_in[l][j] = '0;
      end
    end

    plsum_lane u_lane (
      .chunk_i (lane_in[l]),
      .pfx_o   (lane_pfx[l]),
      .total_o (lane_tot[l])
    );
  end

  // Gather the in-lane running sums back into element order.
  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_part
    localparam int unsigned LN = lane_of(k);
    localparam int unsigned JX = k - chunk_start(LN);
    assign part_w[k] = lane_pfx[LN][JX];
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tree_in.tot[l] = lane_tot[l];
    end
    for (int k = 0; k < NUM_ELEMS; k++) begin
      tree_in.part[k] = part_w[k];
    end
    tree_in.last = in_data_i.last;
  end

  // Exclusive scan of the lane totals.
  plsum_tree u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (tree_in),
    .out_valid_o (tree_vld),
    .out_ready_i (tree_rdy),
    .out_data_o  (tree_out)
  );

  // Apply lane offsets and the carry of earlier vectors.
  plsum_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tree_vld),
    .in_ready_o  (tree_rdy),
    .in_data_i   (tree_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
